@@ rtl/core/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, constants and control structs of the score table.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int TBL_CNT_W   = TBL_AW + 1;
    localparam logic [TBL_CNT_W-1:0] TBL_CNT_FULL = TBL_CNT_W'(TABLE_DEPTH);

    localparam int KEY_W      = 64;
    localparam int TIME_W     = 32;
    localparam int SCORE_W    = 6;
    localparam int STEP_W     = 4;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int REMOVED_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 16;

    localparam logic [REMOVED_W-1:0] REMOVED_SAT = {REMOVED_W{1'b1}};
    localparam logic [TIME_W-1:0]    TIME_SAT    = {TIME_W{1'b1}};

    // score arithmetic is done one bit wider than the stored score
    localparam logic signed [SCORE_W:0] SCORE_MAX = 7'sd16;
    localparam logic signed [SCORE_W:0] SCORE_MIN = -7'sd16;

    localparam logic [STEP_W-1:0] RAISE_STEP_RST     = 4'd1;
    localparam logic [STEP_W-1:0] LOWER_STEP_RST     = 4'd2;
    localparam logic [TIME_W-1:0] MAX_AGE_RST        = 32'd86400;
    localparam logic [TIME_W-1:0] SWEEP_INTERVAL_RST = 32'd3600;

    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_INTERVAL = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_RAISE = 2'd0,
        CMD_LOWER = 2'd1,
        CMD_READ  = 2'd2,
        CMD_SWEEP = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_SWEPT   = 2'd2,
        STAT_NOT_DUE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [TIME_W-1:0]         touch;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic start;
        logic scan;
        logic update;
        logic load_out;
    } dp_ctrl_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/sst_ram.sv @@
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/sst_ctrl.sv @@
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: accept, table scan, update, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire sst_pkg::dp_stat_t stat,
    output sst_pkg::dp_ctrl_t      ctl
);

    sst_pkg::ctrl_state_t state_reg;
    sst_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sst_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ctl          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            sst_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.start  = 1'b1;
                    state_next = sst_pkg::ST_SCAN;
                end
            end
            sst_pkg::ST_SCAN: begin
                ctl.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = sst_pkg::ST_UPDATE;
                end
            end
            sst_pkg::ST_UPDATE: begin
                ctl.update = 1'b1;
                state_next = sst_pkg::ST_RESULT;
            end
            sst_pkg::ST_RESULT: begin
                // wait until the output register can take the result
                if (stat.out_free) begin
                    ctl.load_out = 1'b1;
                    state_next   = sst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/sst_datapath.sv @@
// ----------------------------------------------------------------------------
// sst_datapath
// Entry memory, valid bits, config registers, scan and score logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [sst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sst_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic [sst_pkg::CMD_W-1:0]        s_tuser,
    input  wire logic [sst_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [sst_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire sst_pkg::dp_ctrl_t                ctl,
    output sst_pkg::dp_stat_t                     stat
);

    // config
    logic [sst_pkg::STEP_W-1:0] raise_step_reg;
    logic [sst_pkg::STEP_W-1:0] lower_step_reg;
    logic [sst_pkg::TIME_W-1:0] max_age_reg;
    logic [sst_pkg::TIME_W-1:0] interval_reg;

    // item
    sst_pkg::cmd_t              cmd_reg;
    logic [sst_pkg::KEY_W-1:0]  key_reg;
    logic [sst_pkg::TIME_W-1:0] now_reg;

    // table state
    logic [sst_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [sst_pkg::TIME_W-1:0]      next_sweep_reg;

    // scan
    logic [sst_pkg::TBL_CNT_W-1:0]  issue_cnt_reg;
    logic                           pipe_vld_reg;
    logic [sst_pkg::TBL_AW-1:0]     pipe_idx_reg;
    logic                           match_reg;
    logic [sst_pkg::TBL_AW-1:0]     match_idx_reg;
    logic signed [sst_pkg::SCORE_W-1:0] base_reg;
    logic                           free_reg;
    logic [sst_pkg::TBL_AW-1:0]     free_idx_reg;
    logic [sst_pkg::REMOVED_W-1:0]  removed_reg;

    // result
    logic [sst_pkg::SCORE_W-1:0]    res_score_reg;
    logic                           res_found_reg;
    sst_pkg::status_t               res_status_reg;
    logic [sst_pkg::REMOVED_W-1:0]  res_removed_reg;
    logic                           m_valid_reg;
    logic [sst_pkg::M_TDATA_W-1:0]  m_data_reg;

    logic [sst_pkg::ENTRY_W-1:0] rd_raw;
    sst_pkg::entry_t             rd_entry;
    sst_pkg::entry_t             wr_entry;
    logic                        is_lookup;
    logic                        is_update;
    logic                        sweep_due;
    logic                        hit_vld;
    logic                        key_hit;
    logic                        empty_hit;
    logic [sst_pkg::TIME_W-1:0]  age;
    logic                        stale;
    logic                        drop;
    logic                        issue;
    logic                        wr_en;
    logic [sst_pkg::TBL_AW-1:0]  wr_slot;
    logic signed [sst_pkg::SCORE_W:0] base_ext;
    logic signed [sst_pkg::SCORE_W:0] sum;
    logic signed [sst_pkg::SCORE_W:0] new_score;
    logic [sst_pkg::TIME_W:0]    next_sum;
    logic [sst_pkg::SCORE_W-1:0] score_next;
    sst_pkg::status_t            status_next;

    sst_ram #(
        .WIDTH (sst_pkg::ENTRY_W),
        .DEPTH (sst_pkg::TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_slot),
        .wr_data (wr_entry),
        .rd_en   (issue),
        .rd_addr (issue_cnt_reg[sst_pkg::TBL_AW-1:0]),
        .rd_data (rd_raw)
    );

    assign rd_entry = sst_pkg::entry_t'(rd_raw);

    assign is_lookup = (cmd_reg != sst_pkg::CMD_SWEEP);
    assign is_update = (cmd_reg == sst_pkg::CMD_RAISE) || (cmd_reg == sst_pkg::CMD_LOWER);
    assign sweep_due = (now_reg >= next_sweep_reg);

    // entry on the read port is checked in the cycle after its address went out
    assign hit_vld   = pipe_vld_reg && valid_reg[pipe_idx_reg];
    assign key_hit   = hit_vld && is_lookup && !match_reg && (rd_entry.key == key_reg);
    assign empty_hit = pipe_vld_reg && !valid_reg[pipe_idx_reg] && is_lookup && !free_reg;
    assign age       = now_reg - rd_entry.touch;
    assign stale     = (rd_entry.touch > now_reg) || (age > max_age_reg);
    assign drop      = hit_vld && !is_lookup && sweep_due && stale;
    assign issue     = ctl.scan && (issue_cnt_reg != sst_pkg::TBL_CNT_FULL)
                       && !match_reg && !key_hit;

    assign stat.scan_done = match_reg
                            || ((issue_cnt_reg == sst_pkg::TBL_CNT_FULL) && !pipe_vld_reg);
    assign stat.out_free  = !m_valid_reg || m_tready;

    // score step with clamp
    assign base_ext = match_reg ? {base_reg[sst_pkg::SCORE_W-1], base_reg} : '0;
    always_comb begin
        if (cmd_reg == sst_pkg::CMD_RAISE) begin
            sum = base_ext + $signed({3'b000, raise_step_reg});
        end else begin
            sum = base_ext - $signed({3'b000, lower_step_reg});
        end
        if (sum > sst_pkg::SCORE_MAX) begin
            new_score = sst_pkg::SCORE_MAX;
        end else if (sum < sst_pkg::SCORE_MIN) begin
            new_score = sst_pkg::SCORE_MIN;
        end else begin
            new_score = sum;
        end
    end

    assign wr_en   = ctl.update && is_update && (match_reg || free_reg);
    assign wr_slot = match_reg ? match_idx_reg : free_idx_reg;
    assign wr_entry.key   = key_reg;
    assign wr_entry.score = new_score[sst_pkg::SCORE_W-1:0];
    assign wr_entry.touch = now_reg;

    assign next_sum = {1'b0, now_reg} + {1'b0, interval_reg};

    always_comb begin
        score_next  = '0;
        status_next = sst_pkg::STAT_OK;
        if (is_update) begin
            if (match_reg || free_reg) begin
                score_next = new_score[sst_pkg::SCORE_W-1:0];
            end else begin
                status_next = sst_pkg::STAT_FULL;
            end
        end else if (is_lookup) begin
            if (match_reg) begin
                score_next = base_reg;
            end
        end else begin
            status_next = sweep_due ? sst_pkg::STAT_SWEPT : sst_pkg::STAT_NOT_DUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raise_step_reg <= sst_pkg::RAISE_STEP_RST;
            lower_step_reg <= sst_pkg::LOWER_STEP_RST;
            max_age_reg    <= sst_pkg::MAX_AGE_RST;
            interval_reg   <= sst_pkg::SWEEP_INTERVAL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                sst_pkg::CFG_RAISE_STEP:     raise_step_reg <= cfg_wdata[sst_pkg::STEP_W-1:0];
                sst_pkg::CFG_LOWER_STEP:     lower_step_reg <= cfg_wdata[sst_pkg::STEP_W-1:0];
                sst_pkg::CFG_MAX_AGE:        max_age_reg    <= cfg_wdata;
                sst_pkg::CFG_SWEEP_INTERVAL: interval_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            cmd_reg <= sst_pkg::cmd_t'(s_tuser);
            key_reg <= s_tdata[sst_pkg::KEY_W-1:0];
            now_reg <= s_tdata[sst_pkg::KEY_W +: sst_pkg::TIME_W];
        end
        if (key_hit) begin
            match_idx_reg <= pipe_idx_reg;
            base_reg      <= rd_entry.score;
        end
        if (empty_hit) begin
            free_idx_reg <= pipe_idx_reg;
        end
        if (issue) begin
            pipe_idx_reg <= issue_cnt_reg[sst_pkg::TBL_AW-1:0];
        end
        if (ctl.update) begin
            res_score_reg   <= score_next;
            res_found_reg   <= is_lookup && match_reg;
            res_status_reg  <= status_next;
            res_removed_reg <= is_lookup ? '0 : removed_reg;
        end
        if (ctl.load_out) begin
            m_data_reg <= {res_removed_reg, res_status_reg, res_found_reg, res_score_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            next_sweep_reg <= '0;
            issue_cnt_reg  <= '0;
            pipe_vld_reg   <= 1'b0;
            match_reg      <= 1'b0;
            free_reg       <= 1'b0;
            removed_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pipe_vld_reg <= issue;
            if (ctl.start) begin
                issue_cnt_reg <= '0;
                match_reg     <= 1'b0;
                free_reg      <= 1'b0;
                removed_reg   <= '0;
            end else begin
                if (issue) begin
                    issue_cnt_reg <= issue_cnt_reg + sst_pkg::TBL_CNT_W'(1);
                end
                if (key_hit) begin
                    match_reg <= 1'b1;
                end
                if (empty_hit) begin
                    free_reg <= 1'b1;
                end
                if (drop && (removed_reg != sst_pkg::REMOVED_SAT)) begin
                    removed_reg <= removed_reg + sst_pkg::REMOVED_W'(1);
                end
            end
            if (drop) begin
                valid_reg[pipe_idx_reg] <= 1'b0;
            end
            if (wr_en) begin
                valid_reg[wr_slot] <= 1'b1;
            end
            if (ctl.update && !is_lookup && sweep_due) begin
                next_sweep_reg <= next_sum[sst_pkg::TIME_W] ? sst_pkg::TIME_SAT
                                                            : next_sum[sst_pkg::TIME_W-1:0];
            end
            if (ctl.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/saturating_score_table_with_aging.sv @@
// ----------------------------------------------------------------------------
// saturating_score_table_with_aging
// Keyed table of clamped scores with time-based expiry of stale entries.
// ----------------------------------------------------------------------------
// Every item scans the entry memory through its single read port, one entry
// per cycle. A raise, lower or read of a present key stops at the match;
// a miss, a table-full update and a sweep visit all TABLE_DEPTH entries.
// One item is in work at a time; the next transfer is taken once the result
// sits in the output register. There is no clearing pass after reset: valid
// bits are flip-flops.
`default_nettype none

module saturating_score_table_with_aging (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [sst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sst_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [sst_pkg::S_TDATA_W-1:0]  s_tdata,  // dest_id[63:0], now_secs[95:64]
    input  wire logic [sst_pkg::CMD_W-1:0]      s_tuser,  // command[1:0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [sst_pkg::M_TDATA_W-1:0]  m_tdata   // score[5:0], found[6],
                                                          // status[8:7], removed_count[15:9]
);

    sst_pkg::dp_ctrl_t ctl;
    sst_pkg::dp_stat_t stat;

    sst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    sst_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ctl       (ctl),
        .stat      (stat)
    );

endmodule

`default_nettype wire

@@ verif/saturating_score_table_with_aging_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// saturating_score_table_with_aging_tb
// Drives raise, lower, read and sweep commands into the score table under
// random stalls on both streams. A behavioral copy of the table predicts each
// reply, and the replies are checked field by field in order.
// ----------------------------------------------------------------------------

module saturating_score_table_with_aging_tb;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 100;
    localparam int MAX_PRINTS      = 100;

    typedef struct {
        logic signed [sst_pkg::SCORE_W-1:0] score;
        logic                               found;
        sst_pkg::status_t                   status;
        logic [sst_pkg::REMOVED_W-1:0]      removed;
    } score_reply_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic [sst_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sst_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [sst_pkg::S_TDATA_W-1:0]  s_tdata;   // dest_id[63:0], now_secs[95:64]
    logic [sst_pkg::CMD_W-1:0]      s_tuser;   // command[1:0]
    logic                           m_tvalid;
    logic                           m_tready;
    logic [sst_pkg::M_TDATA_W-1:0]  m_tdata;   // score[5:0], found[6], status[8:7],
                                               // removed_count[15:9]

    // behavioral copy of the table and its registers
    logic                        tbl_valid [sst_pkg::TABLE_DEPTH];
    logic [sst_pkg::KEY_W-1:0]   tbl_key   [sst_pkg::TABLE_DEPTH];
    int                          tbl_score [sst_pkg::TABLE_DEPTH];
    logic [sst_pkg::TIME_W-1:0]  tbl_touch [sst_pkg::TABLE_DEPTH];
    logic [sst_pkg::TIME_W-1:0]  sweep_due_at;
    logic [sst_pkg::STEP_W-1:0]  raise_amt;
    logic [sst_pkg::STEP_W-1:0]  lower_amt;
    logic [sst_pkg::TIME_W-1:0]  age_limit;
    logic [sst_pkg::TIME_W-1:0]  sweep_gap;

    score_reply_t score_replies [$];
    int           bad_replies;
    int           src_gap_pct;
    int           sink_gap_pct;
    logic         hold_off_req;
    logic [31:0]  clock_now;

    saturating_score_table_with_aging uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic score_reply_t apply_score_cmd(sst_pkg::cmd_t cmd,
                                                     logic [sst_pkg::KEY_W-1:0] key,
                                                     logic [sst_pkg::TIME_W-1:0] now);
        score_reply_t r;
        int           hit;
        int           slot;
        int           val;
        int           n_gone;
        logic [sst_pkg::TIME_W:0] nxt;
        r.score   = '0;
        r.found   = 1'b0;
        r.status  = sst_pkg::STAT_OK;
        r.removed = '0;
        hit = -1;
        slot = -1;
        for (int i = 0; i < sst_pkg::TABLE_DEPTH; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;
            if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        case (cmd)
            sst_pkg::CMD_RAISE, sst_pkg::CMD_LOWER: begin
                val = 0;
                if (hit >= 0) begin
                    r.found = 1'b1;
                    val = tbl_score[hit];
                    slot = hit;
                end
                if (slot < 0) begin
                    r.status = sst_pkg::STAT_FULL;
                end else begin
                    if (cmd == sst_pkg::CMD_RAISE) val = val + int'(raise_amt);
                    else val = val - int'(lower_amt);
                    if (val > 16) val = 16;
                    if (val < -16) val = -16;
                    r.score = val[sst_pkg::SCORE_W-1:0];
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot]   = key;
                    tbl_score[slot] = val;
                    tbl_touch[slot] = now;
                end
            end
            sst_pkg::CMD_READ: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    val = tbl_score[hit];
                    r.score = val[sst_pkg::SCORE_W-1:0];
                end
            end
            default: begin
                if (now < sweep_due_at) begin
                    r.status = sst_pkg::STAT_NOT_DUE;
                end else begin
                    nxt = {1'b0, now} + {1'b0, sweep_gap};
                    sweep_due_at = nxt[sst_pkg::TIME_W] ? sst_pkg::TIME_SAT
                                                        : nxt[sst_pkg::TIME_W-1:0];
                    n_gone = 0;
                    for (int i = 0; i < sst_pkg::TABLE_DEPTH; i++) begin
                        // an entry touched after now counts as stale
                        if (tbl_valid[i] && (tbl_touch[i] > now ||
                                             now - tbl_touch[i] > age_limit)) begin
                            tbl_valid[i] = 1'b0;
                            n_gone++;
                        end
                    end
                    r.removed = (n_gone > int'(sst_pkg::REMOVED_SAT))
                                ? sst_pkg::REMOVED_SAT : n_gone[sst_pkg::REMOVED_W-1:0];
                    r.status = sst_pkg::STAT_SWEPT;
                end
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(string what);
        bad_replies++;
        if (bad_replies <= MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // caller sits at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(sst_pkg::cmd_t cmd, logic [sst_pkg::KEY_W-1:0] key,
                             logic [sst_pkg::TIME_W-1:0] now);
        int gap;
        score_reply_t r;
        gap = pick_gap(src_gap_pct);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {now, key};
        do @(posedge aclk); while (!s_tready);
        r = apply_score_cmd(cmd, key, now);
        score_replies.insert(score_replies.size(), r);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (score_replies.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic [sst_pkg::CFG_IDX_W-1:0] idx,
                             logic [sst_pkg::CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            sst_pkg::CFG_RAISE_STEP: raise_amt = val[sst_pkg::STEP_W-1:0];
            sst_pkg::CFG_LOWER_STEP: lower_amt = val[sst_pkg::STEP_W-1:0];
            sst_pkg::CFG_MAX_AGE:    age_limit = val;
            default:                 sweep_gap = val;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_item(sst_pkg::CMD_READ,  64'h0, 32'd0);
        send_item(sst_pkg::CMD_SWEEP, 64'h0, 32'd0);
        send_item(sst_pkg::CMD_SWEEP, {sst_pkg::KEY_W{1'b1}}, 32'd3599);
        send_item(sst_pkg::CMD_RAISE, 64'h0, 32'd10);
        send_item(sst_pkg::CMD_LOWER, 64'h0, 32'd20);
        send_item(sst_pkg::CMD_READ,  64'h0, 32'd21);
        send_item(sst_pkg::CMD_RAISE, {sst_pkg::KEY_W{1'b1}}, sst_pkg::TIME_SAT);
    endtask

    task automatic test_step_and_clamp();
        // upper bits of the step writes must be ignored
        write_reg(sst_pkg::CFG_RAISE_STEP, ($urandom() & ~32'hF) | 32'd15);
        write_reg(sst_pkg::CFG_LOWER_STEP, 32'd15);
        send_item(sst_pkg::CMD_RAISE, {sst_pkg::KEY_W{1'b1}}, 32'd30);
        send_item(sst_pkg::CMD_RAISE, {sst_pkg::KEY_W{1'b1}}, 32'd31);
        send_item(sst_pkg::CMD_LOWER, {sst_pkg::KEY_W{1'b1}}, 32'd32);
        send_item(sst_pkg::CMD_LOWER, {sst_pkg::KEY_W{1'b1}}, 32'd33);
        send_item(sst_pkg::CMD_LOWER, {sst_pkg::KEY_W{1'b1}}, 32'd34);
        send_item(sst_pkg::CMD_LOWER, 64'h8000_0000_0000_0001, 32'd35);
        write_reg(sst_pkg::CFG_RAISE_STEP, 32'd0);
        write_reg(sst_pkg::CFG_LOWER_STEP, ($urandom() & ~32'hF));
        send_item(sst_pkg::CMD_RAISE, {sst_pkg::KEY_W{1'b1}}, 32'd40);
        send_item(sst_pkg::CMD_LOWER, 64'h0, 32'd41);
        send_item(sst_pkg::CMD_READ,  {sst_pkg::KEY_W{1'b1}}, 32'd42);
    endtask

    task automatic test_sweep_aging();
        send_item(sst_pkg::CMD_SWEEP, 64'h0, 32'd3600);
        send_item(sst_pkg::CMD_RAISE, 64'h5555_5555_5555_5555, 32'hFFFF_0000);
        send_item(sst_pkg::CMD_RAISE, 64'h0, 32'd20000);
        write_reg(sst_pkg::CFG_MAX_AGE, 32'd1);
        // key 0 sits exactly at the age limit and survives
        send_item(sst_pkg::CMD_SWEEP, 64'h0, 32'd20001);
        send_item(sst_pkg::CMD_READ,  64'h0, 32'd20001);
        send_item(sst_pkg::CMD_SWEEP, 64'h0, 32'd20002);
        send_item(sst_pkg::CMD_READ,  64'h5555_5555_5555_5555, 32'd20002);
    endtask

    task automatic test_backpressure();
        logic [sst_pkg::KEY_W-1:0] key;
        write_reg(sst_pkg::CFG_RAISE_STEP, 32'd5);
        write_reg(sst_pkg::CFG_LOWER_STEP, 32'd3);
        write_reg(sst_pkg::CFG_MAX_AGE, 32'hFFFF_FFFF);
        src_gap_pct  = 0;
        hold_off_req = ~hold_off_req;
        for (int i = 0; i < 12; i++) begin
            key = 64'hBEEF_0000_0000_0000 | 64'($urandom_range(0, 3));
            send_item(i % 3 == 2 ? sst_pkg::CMD_READ
                      : (i % 3 == 1 ? sst_pkg::CMD_LOWER : sst_pkg::CMD_RAISE),
                      key, 32'd25000 + 32'(i));
        end
    endtask

    task automatic test_table_full();
        write_reg(sst_pkg::CFG_RAISE_STEP, 32'd1);
        write_reg(sst_pkg::CFG_LOWER_STEP, 32'd1);
        write_reg(sst_pkg::CFG_SWEEP_INTERVAL, 32'd1);
        src_gap_pct  = 10;
        sink_gap_pct = 10;
        clock_now = 32'd30000;
        for (int i = 0; i < sst_pkg::TABLE_DEPTH + 2; i++) begin
            send_item(sst_pkg::CMD_RAISE, 64'hA5A5_0000_0000_0000 | 64'(i), clock_now);
            clock_now++;
        end
        send_item(sst_pkg::CMD_LOWER, 64'hA5A5_0000_0000_FFFF, clock_now);
        send_item(sst_pkg::CMD_RAISE, 64'hA5A5_0000_0000_0001, clock_now);
        send_item(sst_pkg::CMD_READ,  64'hA5A5_0000_0000_FFFF, clock_now);
        write_reg(sst_pkg::CFG_MAX_AGE, 32'd1);
        clock_now += 32'd100;
        send_item(sst_pkg::CMD_SWEEP, 64'h0, clock_now);
    endtask

    task automatic test_random_traffic(int n_items, int pool_size, int max_dt,
                                       int src_pct, int sink_pct);
        logic [sst_pkg::KEY_W-1:0]  key_pool [$];
        logic [sst_pkg::KEY_W-1:0]  key;
        logic [sst_pkg::TIME_W-1:0] now;
        sst_pkg::cmd_t              cmd;
        int                         pick;
        src_gap_pct  = src_pct;
        sink_gap_pct = sink_pct;
        key_pool.delete();
        key_pool.insert(key_pool.size(), 64'h0);
        key_pool.insert(key_pool.size(), {sst_pkg::KEY_W{1'b1}});
        while (key_pool.size() < pool_size)
            key_pool.insert(key_pool.size(), {$urandom(), $urandom()});
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            cmd  = pick < 35 ? sst_pkg::CMD_RAISE : (pick < 60 ? sst_pkg::CMD_LOWER :
                   (pick < 85 ? sst_pkg::CMD_READ : sst_pkg::CMD_SWEEP));
            if ($urandom_range(0, 9) == 0) key = {$urandom(), $urandom()};
            else key = key_pool[$urandom_range(0, pool_size - 1)];
            clock_now += 32'($urandom_range(0, max_dt));
            now = clock_now;
            // stray timestamps leave entries in the future; never on a sweep
            if (cmd != sst_pkg::CMD_SWEEP && $urandom_range(0, 19) == 0) now = $urandom();
            else if ($urandom_range(0, 9) == 0)
                now = clock_now - 32'($urandom_range(0, 4 * max_dt));
            send_item(cmd, key, now);
        end
    endtask

    task automatic test_sweep_saturation();
        write_reg(sst_pkg::CFG_SWEEP_INTERVAL, 32'hFFFF_FFFF);
        src_gap_pct  = 20;
        sink_gap_pct = 20;
        clock_now += 32'd1000;
        send_item(sst_pkg::CMD_SWEEP, 64'h0, clock_now);
        send_item(sst_pkg::CMD_RAISE, {sst_pkg::KEY_W{1'b1}}, 32'd0);
        send_item(sst_pkg::CMD_SWEEP, 64'h0, 32'hFFFF_FFFE);
        send_item(sst_pkg::CMD_SWEEP, 64'h0, sst_pkg::TIME_SAT);
        send_item(sst_pkg::CMD_READ,  {sst_pkg::KEY_W{1'b1}}, sst_pkg::TIME_SAT);
    endtask

    always @(posedge aclk) begin : check_replies
        score_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (score_replies.size() == 0) begin
                report_mismatch($sformatf("result with none outstanding, tdata %h", m_tdata));
            end else begin
                want = score_replies.pop_front();
                if (m_tdata[5:0] !== want.score)
                    report_mismatch($sformatf("score %0d, want %0d",
                                              $signed(m_tdata[5:0]), want.score));
                if (m_tdata[6] !== want.found)
                    report_mismatch($sformatf("found %b, want %b", m_tdata[6], want.found));
                if (m_tdata[8:7] !== want.status)
                    report_mismatch($sformatf("status %0d, want %s",
                                              m_tdata[8:7], want.status.name()));
                if (m_tdata[15:9] !== want.removed)
                    report_mismatch($sformatf("removed_count %0d, want %0d",
                                              m_tdata[15:9], want.removed));
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : drive_ready
        int   hold;
        logic hold_off_ack;
        m_tready     = 1'b0;
        hold         = 0;
        hold_off_ack = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req != hold_off_ack) begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_ack = hold_off_req;
                hold = 0;
            end else begin
                if (hold == 0) hold = pick_gap(sink_gap_pct);
                if (hold > 0) begin
                    m_tready = 1'b0;
                    hold--;
                end else begin
                    m_tready = 1'b1;
                end
            end
        end
    end

    initial begin : run_limit
        #4_000_000;
        $display("saturating_score_table_with_aging_tb NOT OK");
        $finish;
    end

    initial begin : run_tests
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = sst_pkg::CFG_RAISE_STEP;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = sst_pkg::CMD_RAISE;
        hold_off_req = 1'b0;
        src_gap_pct  = 30;
        sink_gap_pct = 30;
        bad_replies  = 0;
        clock_now    = '0;
        for (int i = 0; i < sst_pkg::TABLE_DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_score[i] = 0;
            tbl_touch[i] = '0;
        end
        sweep_due_at = '0;
        raise_amt    = sst_pkg::RAISE_STEP_RST;
        lower_amt    = sst_pkg::LOWER_STEP_RST;
        age_limit    = sst_pkg::MAX_AGE_RST;
        sweep_gap    = sst_pkg::SWEEP_INTERVAL_RST;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_step_and_clamp();
        test_sweep_aging();
        test_backpressure();
        test_table_full();

        write_reg(sst_pkg::CFG_RAISE_STEP, 32'd1);
        write_reg(sst_pkg::CFG_LOWER_STEP, 32'd1);
        write_reg(sst_pkg::CFG_MAX_AGE, 32'd40);
        write_reg(sst_pkg::CFG_SWEEP_INTERVAL, 32'd20);
        test_random_traffic(110, 24, 6, 30, 30);

        // no aging, so the table runs full
        write_reg(sst_pkg::CFG_RAISE_STEP, ($urandom() & ~32'hF) | 32'd15);
        write_reg(sst_pkg::CFG_LOWER_STEP, 32'd7);
        write_reg(sst_pkg::CFG_MAX_AGE, 32'hFFFF_FFFF);
        write_reg(sst_pkg::CFG_SWEEP_INTERVAL, 32'd1);
        test_random_traffic(110, 80, 4, 0, 0);

        write_reg(sst_pkg::CFG_RAISE_STEP, 32'd3);
        write_reg(sst_pkg::CFG_LOWER_STEP, 32'd5);
        write_reg(sst_pkg::CFG_MAX_AGE, 32'd1);
        write_reg(sst_pkg::CFG_SWEEP_INTERVAL, 32'd1);
        test_random_traffic(110, 10, 3, 50, 50);

        write_reg(sst_pkg::CFG_RAISE_STEP,
                  ($urandom() & ~32'hF) | 32'($urandom_range(0, 15)));
        write_reg(sst_pkg::CFG_LOWER_STEP,
                  ($urandom() & ~32'hF) | 32'($urandom_range(0, 15)));
        write_reg(sst_pkg::CFG_MAX_AGE, 32'($urandom_range(1, 200)));
        write_reg(sst_pkg::CFG_SWEEP_INTERVAL, 32'($urandom_range(1, 100)));
        test_random_traffic(110, 70, 8, 20, 10);

        test_sweep_saturation();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (bad_replies == 0) begin
            $display("saturating_score_table_with_aging_tb OK");
        end else begin
            $display("saturating_score_table_with_aging_tb NOT OK");
        end
        $finish;
    end

endmodule
